[hdl/rigid_pose_compose_macros.svh]
// Assertion macros shared by the rigid pose composition RTL.
// Each macro expects clk and rst_n to be visible in the enclosing module.
`ifndef RIGID_POSE_COMPOSE_MACROS_SVH
`define RIGID_POSE_COMPOSE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RPC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RPC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/rpc_pkg.sv]
// Package for the rigid pose composition block: widths, register indices,
// the parent pose record and the saturation helpers.
// Used by every other file of the block but the assertion macros.
package rpc_pkg;

    localparam int Q_W            = 16;
    localparam int P_W            = 32;
    localparam int QUAT_FRAC_BITS = 14;

    localparam int QP_W   = 2 * Q_W;
    localparam int QSUM_W = QP_W + 2;
    localparam int QRND_W = QSUM_W - QUAT_FRAC_BITS;
    localparam int CP_W   = Q_W + P_W;
    localparam int CSUM_W = CP_W + 2;
    localparam int D_W    = CSUM_W - QUAT_FRAC_BITS;
    localparam int RP_W   = Q_W + D_W;
    localparam int RSUM_W = RP_W + 2;
    localparam int R_W    = RSUM_W - QUAT_FRAC_BITS;
    localparam int PSUM_W = ((R_W > P_W) ? R_W : P_W) + 2;

    localparam int APB_AW = 5;
    localparam int APB_DW = 32;

    typedef enum logic [2:0] {
        REG_QX,
        REG_QY,
        REG_QZ,
        REG_QW,
        REG_PX,
        REG_PY,
        REG_PZ
    } reg_idx_t;

    localparam logic signed [Q_W-1:0] QW_RESET = Q_W'(1) << QUAT_FRAC_BITS;

    typedef struct packed {
        logic signed [Q_W-1:0] qx;
        logic signed [Q_W-1:0] qy;
        logic signed [Q_W-1:0] qz;
        logic signed [Q_W-1:0] qw;
        logic signed [P_W-1:0] px;
        logic signed [P_W-1:0] py;
        logic signed [P_W-1:0] pz;
    } parent_t;

    function automatic logic signed [Q_W-1:0] sat_q(input logic signed [QRND_W-1:0] x);
        logic signed [Q_W-1:0] r;
        if ((&x[QRND_W-1:Q_W-1]) || !(|x[QRND_W-1:Q_W-1])) begin
            r = x[Q_W-1:0];
        end
        else if (x[QRND_W-1]) begin
            r = {1'b1, {(Q_W-1){1'b0}}};
        end
        else begin
            r = {1'b0, {(Q_W-1){1'b1}}};
        end
        return r;
    endfunction

    function automatic logic signed [P_W-1:0] sat_p(input logic signed [PSUM_W-1:0] x);
        logic signed [P_W-1:0] r;
        if ((&x[PSUM_W-1:P_W-1]) || !(|x[PSUM_W-1:P_W-1])) begin
            r = x[P_W-1:0];
        end
        else if (x[PSUM_W-1]) begin
            r = {1'b1, {(P_W-1){1'b0}}};
        end
        else begin
            r = {1'b0, {(P_W-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

[hdl/rpc_if.sv]
// Valid/ready stream interfaces for local poses in and composed poses out.
// Field widths follow rpc_pkg.
interface rpc_local_if;
    logic                           valid;
    logic                           ready;
    logic signed [rpc_pkg::Q_W-1:0] local_qx;
    logic signed [rpc_pkg::Q_W-1:0] local_qy;
    logic signed [rpc_pkg::Q_W-1:0] local_qz;
    logic signed [rpc_pkg::Q_W-1:0] local_qw;
    logic signed [rpc_pkg::P_W-1:0] local_px;
    logic signed [rpc_pkg::P_W-1:0] local_py;
    logic signed [rpc_pkg::P_W-1:0] local_pz;

    modport source (
        output valid, local_qx, local_qy, local_qz, local_qw, local_px, local_py, local_pz,
        input  ready
    );
    modport sink (
        input  valid, local_qx, local_qy, local_qz, local_qw, local_px, local_py, local_pz,
        output ready
    );
endinterface

interface rpc_world_if;
    logic                           valid;
    logic                           ready;
    logic signed [rpc_pkg::Q_W-1:0] out_qx;
    logic signed [rpc_pkg::Q_W-1:0] out_qy;
    logic signed [rpc_pkg::Q_W-1:0] out_qz;
    logic signed [rpc_pkg::Q_W-1:0] out_qw;
    logic signed [rpc_pkg::P_W-1:0] out_px;
    logic signed [rpc_pkg::P_W-1:0] out_py;
    logic signed [rpc_pkg::P_W-1:0] out_pz;

    modport source (
        output valid, out_qx, out_qy, out_qz, out_qw, out_px, out_py, out_pz,
        input  ready
    );
    modport sink (
        input  valid, out_qx, out_qy, out_qz, out_qw, out_px, out_py, out_pz,
        output ready
    );
endinterface

[hdl/rpc_cfg_regs.sv]
// APB register file holding the parent pose.
// Depends on rpc_pkg for the register indices and the parent pose record.
module rpc_cfg_regs (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [rpc_pkg::APB_AW-1:0]      paddr,
    input  logic [rpc_pkg::APB_DW-1:0]      pwdata,
    output logic [rpc_pkg::APB_DW-1:0]      prdata,
    output logic                            pready,
    output rpc_pkg::parent_t                parent
);

    localparam int Q_W = rpc_pkg::Q_W;
    localparam int P_W = rpc_pkg::P_W;
    localparam int DW  = rpc_pkg::APB_DW;

    rpc_pkg::parent_t  parent_reg;
    rpc_pkg::parent_t  parent_next;
    rpc_pkg::reg_idx_t idx;
    logic              wr_en;

    assign idx    = rpc_pkg::reg_idx_t'(paddr[rpc_pkg::APB_AW-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign parent = parent_reg;

    always_comb
    begin
        parent_next = parent_reg;
        if (wr_en)
        begin
            unique case (idx)
                rpc_pkg::REG_QX: parent_next.qx = pwdata[Q_W-1:0];
                rpc_pkg::REG_QY: parent_next.qy = pwdata[Q_W-1:0];
                rpc_pkg::REG_QZ: parent_next.qz = pwdata[Q_W-1:0];
                rpc_pkg::REG_QW: parent_next.qw = pwdata[Q_W-1:0];
                rpc_pkg::REG_PX: parent_next.px = pwdata[P_W-1:0];
                rpc_pkg::REG_PY: parent_next.py = pwdata[P_W-1:0];
                rpc_pkg::REG_PZ: parent_next.pz = pwdata[P_W-1:0];
                default:         parent_next = parent_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            parent_reg <= '{qx: '0, qy: '0, qz: '0, qw: rpc_pkg::QW_RESET,
                           px: '0, py: '0, pz: '0};
        end
        else
        begin
            parent_reg <= parent_next;
        end
    end

    always_comb
    begin
        unique case (idx)
            rpc_pkg::REG_QX: prdata = DW'(unsigned'(parent_reg.qx));
            rpc_pkg::REG_QY: prdata = DW'(unsigned'(parent_reg.qy));
            rpc_pkg::REG_QZ: prdata = DW'(unsigned'(parent_reg.qz));
            rpc_pkg::REG_QW: prdata = DW'(unsigned'(parent_reg.qw));
            rpc_pkg::REG_PX: prdata = DW'(unsigned'(parent_reg.px));
            rpc_pkg::REG_PY: prdata = DW'(unsigned'(parent_reg.py));
            rpc_pkg::REG_PZ: prdata = DW'(unsigned'(parent_reg.pz));
            default:         prdata = '0;
        endcase
    end

endmodule

[hdl/rigid_pose_compose.sv]
// Top level of the rigid pose composition block: five-stage multiplier pipeline.
// Depends on rpc_pkg, rpc_if, rpc_cfg_regs and rigid_pose_compose_macros.svh.
//
// Use of the block:
// The parent pose is written over the APB port: registers at byte addresses 0, 4,
// 8 and 12 hold the parent quaternion x, y, z and w (signed Q2.14) and 16, 20 and
// 24 the parent position x, y and z (signed Q16.16). The user must make writes
// only while no beat is in flight; the block does not enforce it. Each beat on
// local_pose carries a local pose; one beat leaves on world_pose with the
// composed orientation and the position in the parent frame, both saturated to
// their field widths. One beat is taken every cycle unless the receiver stalls
// with every stage full; the two rounds of multipliers each have their own
// register stage and are each followed by an add-and-round stage.
// Reset clears the pipeline and loads the identity parent pose.
// When the receiver stalls, each stage holds its beat and bubbles are squeezed out,
// so local_pose keeps accepting until every stage is full.
`include "rigid_pose_compose_macros.svh"

module rigid_pose_compose (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rpc_pkg::APB_AW-1:0]  paddr,
    input  logic [rpc_pkg::APB_DW-1:0]  pwdata,
    output logic [rpc_pkg::APB_DW-1:0]  prdata,
    output logic                        pready,
    rpc_local_if.sink                   local_pose,
    rpc_world_if.source                 world_pose
);

    localparam int Q_W    = rpc_pkg::Q_W;
    localparam int P_W    = rpc_pkg::P_W;
    localparam int QF     = rpc_pkg::QUAT_FRAC_BITS;
    localparam int QP_W   = rpc_pkg::QP_W;
    localparam int QSUM_W = rpc_pkg::QSUM_W;
    localparam int QRND_W = rpc_pkg::QRND_W;
    localparam int CP_W   = rpc_pkg::CP_W;
    localparam int CSUM_W = rpc_pkg::CSUM_W;
    localparam int D_W    = rpc_pkg::D_W;
    localparam int RP_W   = rpc_pkg::RP_W;
    localparam int RSUM_W = rpc_pkg::RSUM_W;
    localparam int R_W    = rpc_pkg::R_W;
    localparam int PSUM_W = rpc_pkg::PSUM_W;

    localparam logic signed [QSUM_W-1:0] QHALF = QSUM_W'(1) << (QF - 1);
    localparam logic signed [CSUM_W-1:0] CHALF = CSUM_W'(1) << (QF - 1);
    localparam logic signed [RSUM_W-1:0] RHALF = RSUM_W'(1) << (QF - 1);

    rpc_pkg::parent_t parent;

    rpc_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .parent  (parent)
    );

    logic s1_v_reg, s2_v_reg, s3_v_reg, s4_v_reg, out_v_reg;
    logic en1, en2, en3, en4, en_out;

    assign en_out = !out_v_reg || world_pose.ready;
    assign en4    = !s4_v_reg || en_out;
    assign en3    = !s3_v_reg || en4;
    assign en2    = !s2_v_reg || en3;
    assign en1    = !s1_v_reg || en2;

    assign local_pose.ready = en1;
    assign world_pose.valid = out_v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg  <= 1'b0;
            s2_v_reg  <= 1'b0;
            s3_v_reg  <= 1'b0;
            s4_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                s1_v_reg <= local_pose.valid;
            end
            if (en2)
            begin
                s2_v_reg <= s1_v_reg;
            end
            if (en3)
            begin
                s3_v_reg <= s2_v_reg;
            end
            if (en4)
            begin
                s4_v_reg <= s3_v_reg;
            end
            if (en_out)
            begin
                out_v_reg <= s4_v_reg;
            end
        end
    end

    // Stage 1: quaternion products and the cross product terms of parent_q x v.
    logic signed [QP_W-1:0] s1_pq_next [16];
    logic signed [CP_W-1:0] s1_pc_next [6];
    logic signed [QP_W-1:0] s1_pq_reg  [16];
    logic signed [CP_W-1:0] s1_pc_reg  [6];
    logic signed [P_W-1:0]  s1_pos_reg [3];

    always_comb
    begin
        s1_pq_next[0]  = QP_W'(parent.qw) * QP_W'(local_pose.local_qx);
        s1_pq_next[1]  = QP_W'(parent.qx) * QP_W'(local_pose.local_qw);
        s1_pq_next[2]  = QP_W'(parent.qy) * QP_W'(local_pose.local_qz);
        s1_pq_next[3]  = QP_W'(parent.qz) * QP_W'(local_pose.local_qy);
        s1_pq_next[4]  = QP_W'(parent.qw) * QP_W'(local_pose.local_qy);
        s1_pq_next[5]  = QP_W'(parent.qx) * QP_W'(local_pose.local_qz);
        s1_pq_next[6]  = QP_W'(parent.qy) * QP_W'(local_pose.local_qw);
        s1_pq_next[7]  = QP_W'(parent.qz) * QP_W'(local_pose.local_qx);
        s1_pq_next[8]  = QP_W'(parent.qw) * QP_W'(local_pose.local_qz);
        s1_pq_next[9]  = QP_W'(parent.qx) * QP_W'(local_pose.local_qy);
        s1_pq_next[10] = QP_W'(parent.qy) * QP_W'(local_pose.local_qx);
        s1_pq_next[11] = QP_W'(parent.qz) * QP_W'(local_pose.local_qw);
        s1_pq_next[12] = QP_W'(parent.qw) * QP_W'(local_pose.local_qw);
        s1_pq_next[13] = QP_W'(parent.qx) * QP_W'(local_pose.local_qx);
        s1_pq_next[14] = QP_W'(parent.qy) * QP_W'(local_pose.local_qy);
        s1_pq_next[15] = QP_W'(parent.qz) * QP_W'(local_pose.local_qz);

        s1_pc_next[0]  = CP_W'(parent.qy) * CP_W'(local_pose.local_pz);
        s1_pc_next[1]  = CP_W'(parent.qz) * CP_W'(local_pose.local_py);
        s1_pc_next[2]  = CP_W'(parent.qz) * CP_W'(local_pose.local_px);
        s1_pc_next[3]  = CP_W'(parent.qx) * CP_W'(local_pose.local_pz);
        s1_pc_next[4]  = CP_W'(parent.qx) * CP_W'(local_pose.local_py);
        s1_pc_next[5]  = CP_W'(parent.qy) * CP_W'(local_pose.local_px);
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_pq_reg     <= s1_pq_next;
            s1_pc_reg     <= s1_pc_next;
            s1_pos_reg[0] <= local_pose.local_px;
            s1_pos_reg[1] <= local_pose.local_py;
            s1_pos_reg[2] <= local_pose.local_pz;
        end
    end

    // Stage 2: quaternion sums rounded, and d = round(2 * (a x v)).
    logic signed [QSUM_W-1:0] q_sum [4];
    logic signed [CSUM_W-1:0] c_sum [3];
    logic signed [QRND_W-1:0] s2_q_next   [4];
    logic signed [D_W-1:0]    s2_d_next   [3];
    logic signed [QRND_W-1:0] s2_q_reg    [4];
    logic signed [D_W-1:0]    s2_d_reg    [3];
    logic signed [P_W-1:0]    s2_pos_reg  [3];

    always_comb
    begin
        q_sum[0] = QSUM_W'(s1_pq_reg[0]) + QSUM_W'(s1_pq_reg[1])
                 + QSUM_W'(s1_pq_reg[2]) - QSUM_W'(s1_pq_reg[3]) + QHALF;
        q_sum[1] = QSUM_W'(s1_pq_reg[4]) - QSUM_W'(s1_pq_reg[5])
                 + QSUM_W'(s1_pq_reg[6]) + QSUM_W'(s1_pq_reg[7]) + QHALF;
        q_sum[2] = QSUM_W'(s1_pq_reg[8]) + QSUM_W'(s1_pq_reg[9])
                 - QSUM_W'(s1_pq_reg[10]) + QSUM_W'(s1_pq_reg[11]) + QHALF;
        q_sum[3] = QSUM_W'(s1_pq_reg[12]) - QSUM_W'(s1_pq_reg[13])
                 - QSUM_W'(s1_pq_reg[14]) - QSUM_W'(s1_pq_reg[15]) + QHALF;
        for (int i = 0; i < 4; i++)
        begin
            s2_q_next[i] = q_sum[i][QSUM_W-1:QF];
        end
        for (int j = 0; j < 3; j++)
        begin
            c_sum[j] = ((CSUM_W'(s1_pc_reg[2*j]) - CSUM_W'(s1_pc_reg[2*j+1])) <<< 1) + CHALF;
            s2_d_next[j] = c_sum[j][CSUM_W-1:QF];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            s2_q_reg   <= s2_q_next;
            s2_d_reg   <= s2_d_next;
            s2_pos_reg <= s1_pos_reg;
        end
    end

    // Stage 3: products of the parent quaternion with d.
    logic signed [RP_W-1:0]   s3_rp_next [9];
    logic signed [RP_W-1:0]   s3_rp_reg  [9];
    logic signed [QRND_W-1:0] s3_q_reg   [4];
    logic signed [P_W-1:0]    s3_pos_reg [3];

    always_comb
    begin
        s3_rp_next[0] = RP_W'(parent.qw) * RP_W'(s2_d_reg[0]);
        s3_rp_next[1] = RP_W'(parent.qy) * RP_W'(s2_d_reg[2]);
        s3_rp_next[2] = RP_W'(parent.qz) * RP_W'(s2_d_reg[1]);
        s3_rp_next[3] = RP_W'(parent.qw) * RP_W'(s2_d_reg[1]);
        s3_rp_next[4] = RP_W'(parent.qz) * RP_W'(s2_d_reg[0]);
        s3_rp_next[5] = RP_W'(parent.qx) * RP_W'(s2_d_reg[2]);
        s3_rp_next[6] = RP_W'(parent.qw) * RP_W'(s2_d_reg[2]);
        s3_rp_next[7] = RP_W'(parent.qx) * RP_W'(s2_d_reg[1]);
        s3_rp_next[8] = RP_W'(parent.qy) * RP_W'(s2_d_reg[0]);
    end

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            s3_rp_reg  <= s3_rp_next;
            s3_q_reg   <= s2_q_reg;
            s3_pos_reg <= s2_pos_reg;
        end
    end

    // Stage 4: rotation offset rounded, quaternion saturated.
    logic signed [RSUM_W-1:0] r_sum [3];
    logic signed [R_W-1:0]    s4_r_next   [3];
    logic signed [Q_W-1:0]    s4_q_next   [4];
    logic signed [R_W-1:0]    s4_r_reg    [3];
    logic signed [Q_W-1:0]    s4_q_reg    [4];
    logic signed [P_W-1:0]    s4_pos_reg  [3];

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            r_sum[j] = RSUM_W'(s3_rp_reg[3*j]) + RSUM_W'(s3_rp_reg[3*j+1])
                     - RSUM_W'(s3_rp_reg[3*j+2]) + RHALF;
            s4_r_next[j] = r_sum[j][RSUM_W-1:QF];
        end
        for (int i = 0; i < 4; i++)
        begin
            s4_q_next[i] = rpc_pkg::sat_q(s3_q_reg[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            s4_r_reg   <= s4_r_next;
            s4_q_reg   <= s4_q_next;
            s4_pos_reg <= s3_pos_reg;
        end
    end

    // Output stage: parent position plus local position plus offset.
    logic signed [PSUM_W-1:0] p_sum [3];
    logic signed [P_W-1:0]    out_p_next [3];
    logic signed [P_W-1:0]    out_p_reg  [3];
    logic signed [Q_W-1:0]    out_q_reg  [4];

    always_comb
    begin
        p_sum[0] = PSUM_W'(parent.px) + PSUM_W'(s4_pos_reg[0]) + PSUM_W'(s4_r_reg[0]);
        p_sum[1] = PSUM_W'(parent.py) + PSUM_W'(s4_pos_reg[1]) + PSUM_W'(s4_r_reg[1]);
        p_sum[2] = PSUM_W'(parent.pz) + PSUM_W'(s4_pos_reg[2]) + PSUM_W'(s4_r_reg[2]);
        for (int j = 0; j < 3; j++)
        begin
            out_p_next[j] = rpc_pkg::sat_p(p_sum[j]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_out)
        begin
            out_p_reg <= out_p_next;
            out_q_reg <= s4_q_reg;
        end
    end

    assign world_pose.out_qx = out_q_reg[0];
    assign world_pose.out_qy = out_q_reg[1];
    assign world_pose.out_qz = out_q_reg[2];
    assign world_pose.out_qw = out_q_reg[3];
    assign world_pose.out_px = out_p_reg[0];
    assign world_pose.out_py = out_p_reg[1];
    assign world_pose.out_pz = out_p_reg[2];

    `RPC_ASSERT_NEXT(a_stage_advance, s1_v_reg && en2, s2_v_reg, "Stage one beat was lost.")
    `RPC_ASSERT_NOW(a_empty_ready, !(s1_v_reg || s2_v_reg || s3_v_reg || s4_v_reg || out_v_reg), local_pose.ready, "Empty pipeline refused a beat.")
    `RPC_ASSERT_NOW(a_full_ready, s1_v_reg && s2_v_reg && s3_v_reg && s4_v_reg && out_v_reg, local_pose.ready == world_pose.ready, "Full pipeline ready mismatch.")
    `RPC_ASSERT_NEXT(a_bad_index, psel && penable && pwrite && (paddr[rpc_pkg::APB_AW-1:2] > rpc_pkg::REG_PZ), $stable(parent), "Unmapped write changed the parent pose.")

endmodule

[test/tb_rigid_pose_compose.sv]
// Testbench for rigid_pose_compose: local poses are streamed in under several parent poses
// and every composed pose is checked against a typed-in result or a behavioural model of the arithmetic.
// Depends on rpc_pkg, the stream interfaces in rpc_if and the block's RTL.
module tb_rigid_pose_compose;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int Q_W            = rpc_pkg::Q_W;
    localparam int P_W            = rpc_pkg::P_W;
    localparam int APB_AW         = rpc_pkg::APB_AW;
    localparam int APB_DW         = rpc_pkg::APB_DW;
    localparam int QUAT_FRAC_BITS = rpc_pkg::QUAT_FRAC_BITS;

    typedef rpc_pkg::parent_t pose_t;

    typedef enum int {
        GEN_RAW,
        GEN_NEAR,
        GEN_CORNER
    } gen_mode_t;

    typedef struct {
        bit    load;
        pose_t parent;
        pose_t stim;
        bit    typed;
        pose_t want;
    } directed_row_t;

    localparam int     REG_UNUSED = 7;
    localparam longint Q_ONE      = 16384;
    localparam longint QMAX       = 32767;
    localparam longint QMIN       = -32768;
    localparam longint PMAX       = 64'sd2147483647;
    localparam longint PMIN       = -64'sd2147483648;

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    rpc_local_if local_pose ();
    rpc_world_if world_pose ();

    rigid_pose_compose dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .local_pose (local_pose),
        .world_pose (world_pose)
    );

    pose_t         parent_regs;
    pose_t         expected_world[$];
    directed_row_t directed_rows[$];
    int            mismatch_count;
    int            send_idle_pct;
    int            sink_stall_pct;
    int            backpressure_cycles;

    function automatic longint round_frac(input longint x);
        return (x + (longint'(1) << (QUAT_FRAC_BITS - 1))) >>> QUAT_FRAC_BITS;
    endfunction

    function automatic longint saturate(input longint x, input int w);
        longint hi;
        longint lo;
        hi = (longint'(1) << (w - 1)) - 1;
        lo = -hi - 1;
        if (x > hi)
        begin
            return hi;
        end
        if (x < lo)
        begin
            return lo;
        end
        return x;
    endfunction

    // Hamilton product for the orientation; position is parent_p + v + w*d + a x d,
    // with d = 2(a x v) rounded once and kept wide.
    function automatic pose_t compose_with_parent(input pose_t parent, input pose_t loc);
        longint ax, ay, az, aw, bx, by, bz, bw;
        longint vx, vy, vz, cx, cy, cz, dx, dy, dz;
        pose_t  res;
        ax = parent.qx;
        ay = parent.qy;
        az = parent.qz;
        aw = parent.qw;
        cx = parent.px;
        cy = parent.py;
        cz = parent.pz;
        bx = loc.qx;
        by = loc.qy;
        bz = loc.qz;
        bw = loc.qw;
        vx = loc.px;
        vy = loc.py;
        vz = loc.pz;
        res.qx = Q_W'(saturate(round_frac(aw * bx + ax * bw + ay * bz - az * by), Q_W));
        res.qy = Q_W'(saturate(round_frac(aw * by - ax * bz + ay * bw + az * bx), Q_W));
        res.qz = Q_W'(saturate(round_frac(aw * bz + ax * by - ay * bx + az * bw), Q_W));
        res.qw = Q_W'(saturate(round_frac(aw * bw - ax * bx - ay * by - az * bz), Q_W));
        dx = round_frac(2 * (ay * vz - az * vy));
        dy = round_frac(2 * (az * vx - ax * vz));
        dz = round_frac(2 * (ax * vy - ay * vx));
        res.px = P_W'(saturate(cx + vx + round_frac(aw * dx + ay * dz - az * dy), P_W));
        res.py = P_W'(saturate(cy + vy + round_frac(aw * dy + az * dx - ax * dz), P_W));
        res.pz = P_W'(saturate(cz + vz + round_frac(aw * dz + ax * dy - ay * dx), P_W));
        return res;
    endfunction

    function automatic pose_t make_pose(input longint qx, input longint qy, input longint qz,
                                        input longint qw, input longint px, input longint py,
                                        input longint pz);
        pose_t res;
        res.qx = Q_W'(qx);
        res.qy = Q_W'(qy);
        res.qz = Q_W'(qz);
        res.qw = Q_W'(qw);
        res.px = P_W'(px);
        res.py = P_W'(py);
        res.pz = P_W'(pz);
        return res;
    endfunction

    function automatic longint random_field(input int w, input gen_mode_t mode);
        longint lim;
        longint top;
        lim = (w == Q_W) ? 16384 : (longint'(1) << 20);
        top = (longint'(1) << (w - 1)) - 1;
        case (mode)
            GEN_NEAR:
            begin
                return longint'($urandom_range(0, 32'(2 * lim))) - lim;
            end
            GEN_CORNER:
            begin
                case ($urandom_range(0, 5))
                    0: return top;
                    1: return -top - 1;
                    2: return 0;
                    3: return -1;
                    4: return 1;
                    default: return longint'($urandom());
                endcase
            end
            default:
            begin
                return longint'($urandom());
            end
        endcase
    endfunction

    function automatic pose_t random_pose();
        gen_mode_t mode;
        int        pick;
        pick = $urandom_range(0, 9);
        mode = (pick < 4) ? GEN_RAW : (pick < 8) ? GEN_NEAR : GEN_CORNER;
        return make_pose(random_field(Q_W, mode), random_field(Q_W, mode),
                         random_field(Q_W, mode), random_field(Q_W, mode),
                         random_field(P_W, mode), random_field(P_W, mode),
                         random_field(P_W, mode));
    endfunction

    function automatic bit field_differs(input string name, input logic signed [31:0] want,
                                         input logic signed [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic add_row(input bit load, input pose_t parent, input pose_t stim,
                           input bit typed, input pose_t want);
        directed_row_t row;
        row.load   = load;
        row.parent = parent;
        row.stim   = stim;
        row.typed  = typed;
        row.want   = want;
        directed_rows.push_back(row);
    endtask

    task automatic write_parent_reg(input int idx, input logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'(idx * 4);
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            rpc_pkg::REG_QX: parent_regs.qx = value[Q_W-1:0];
            rpc_pkg::REG_QY: parent_regs.qy = value[Q_W-1:0];
            rpc_pkg::REG_QZ: parent_regs.qz = value[Q_W-1:0];
            rpc_pkg::REG_QW: parent_regs.qw = value[Q_W-1:0];
            rpc_pkg::REG_PX: parent_regs.px = value;
            rpc_pkg::REG_PY: parent_regs.py = value;
            rpc_pkg::REG_PZ: parent_regs.pz = value;
            default: ;
        endcase
    endtask

    // Upper bits of the quaternion registers carry noise, and the unused index
    // gets a write that must change nothing.
    task automatic load_parent(input pose_t p);
        write_parent_reg(rpc_pkg::REG_QX, {16'($urandom()), p.qx});
        write_parent_reg(rpc_pkg::REG_QY, {16'($urandom()), p.qy});
        write_parent_reg(rpc_pkg::REG_QZ, {16'($urandom()), p.qz});
        write_parent_reg(rpc_pkg::REG_QW, {16'($urandom()), p.qw});
        write_parent_reg(rpc_pkg::REG_PX, p.px);
        write_parent_reg(rpc_pkg::REG_PY, p.py);
        write_parent_reg(rpc_pkg::REG_PZ, p.pz);
        write_parent_reg(REG_UNUSED, $urandom());
    endtask

    task automatic quiesce_stream();
        local_pose.valid <= 1'b0;
        while (expected_world.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic send_pose(input pose_t stim, input bit typed, input pose_t want);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            local_pose.valid <= 1'b0;
            @(posedge clk);
        end
        local_pose.valid    <= 1'b1;
        local_pose.local_qx <= stim.qx;
        local_pose.local_qy <= stim.qy;
        local_pose.local_qz <= stim.qz;
        local_pose.local_qw <= stim.qw;
        local_pose.local_px <= stim.px;
        local_pose.local_py <= stim.py;
        local_pose.local_pz <= stim.pz;
        @(posedge clk);
        while (!local_pose.ready)
        begin
            @(posedge clk);
        end
        expected_world.push_back(typed ? want : compose_with_parent(parent_regs, stim));
    endtask

    task automatic check_world_beat();
        pose_t got;
        pose_t want;
        bit    bad;
        got = make_pose(world_pose.out_qx, world_pose.out_qy, world_pose.out_qz,
                        world_pose.out_qw, world_pose.out_px, world_pose.out_py,
                        world_pose.out_pz);
        if (expected_world.size() == 0)
        begin
            $display("%0t: unexpected world pose beat, expected none, got %p", $time, got);
            mismatch_count++;
            return;
        end
        want = expected_world.pop_front();
        bad = field_differs("out_qx", want.qx, world_pose.out_qx)
            | field_differs("out_qy", want.qy, world_pose.out_qy)
            | field_differs("out_qz", want.qz, world_pose.out_qz)
            | field_differs("out_qw", want.qw, world_pose.out_qw)
            | field_differs("out_px", want.px, world_pose.out_px)
            | field_differs("out_py", want.py, world_pose.out_py)
            | field_differs("out_pz", want.pz, world_pose.out_pz);
        if (bad)
        begin
            mismatch_count++;
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("tb_rigid_pose_compose: FAIL");
        $finish;
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (world_pose.valid && world_pose.ready)
            begin
                check_world_beat();
            end
            if (backpressure_cycles > 0)
            begin
                world_pose.ready <= 1'b0;
                backpressure_cycles--;
            end
            else
            begin
                world_pose.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
            end
        end
    end

    initial
    begin
        pose_t ident, p_low, p_high, s_zero, s_max, s_min, s_pat1, s_pat2;
        pose_t rot_z, flip_x, half_step;
        rst_n               <= 1'b0;
        psel                <= 1'b0;
        penable             <= 1'b0;
        pwrite              <= 1'b0;
        paddr               <= '0;
        pwdata              <= '0;
        local_pose.valid    <= 1'b0;
        local_pose.local_qx <= '0;
        local_pose.local_qy <= '0;
        local_pose.local_qz <= '0;
        local_pose.local_qw <= '0;
        local_pose.local_px <= '0;
        local_pose.local_py <= '0;
        local_pose.local_pz <= '0;
        world_pose.ready    <= 1'b0;
        mismatch_count      = 0;
        send_idle_pct       = 0;
        sink_stall_pct      = 0;
        backpressure_cycles = 0;
        parent_regs         = make_pose(0, 0, 0, Q_ONE, 0, 0, 0);

        ident     = parent_regs;
        p_low     = make_pose(QMIN, QMIN, QMIN, QMIN, PMIN, PMIN, PMIN);
        p_high    = make_pose(QMAX, QMAX, QMAX, QMAX, PMAX, PMAX, PMAX);
        s_zero    = make_pose(0, 0, 0, 0, 0, 0, 0);
        s_max     = p_high;
        s_min     = p_low;
        s_pat1    = make_pose(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA,
                              32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
        s_pat2    = make_pose(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555,
                              32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);
        rot_z     = make_pose(0, 0, 11585, 11585, 0, 0, 0);
        flip_x    = make_pose(Q_ONE, 0, 0, 0, 1 << 16, -(1 << 16), 0);
        half_step = make_pose(0, 0, 1, Q_ONE, 0, 0, 0);

        // After reset the parent is the identity, so each local pose comes back as it is.
        add_row(1'b0, ident, s_zero, 1'b1, s_zero);
        add_row(1'b0, ident, s_max, 1'b1, s_max);
        add_row(1'b0, ident, s_min, 1'b1, s_min);
        add_row(1'b0, ident, s_pat1, 1'b1, s_pat1);
        add_row(1'b0, ident, s_pat2, 1'b1, s_pat2);
        add_row(1'b1, p_low, s_min, 1'b1, make_pose(QMAX, QMAX, QMAX, QMIN, PMIN, PMIN, PMIN));
        add_row(1'b0, p_low, s_zero, 1'b1, make_pose(0, 0, 0, 0, PMIN, PMIN, PMIN));
        add_row(1'b0, p_low, s_max, 1'b0, s_zero);
        add_row(1'b1, p_high, s_max, 1'b1, make_pose(QMAX, QMAX, QMAX, QMIN, PMAX, PMAX, PMAX));
        add_row(1'b0, p_high, s_min, 1'b0, s_zero);
        add_row(1'b0, p_high, make_pose(0, 0, 0, Q_ONE, PMIN, 0, PMAX), 1'b0, s_zero);
        add_row(1'b1, rot_z, make_pose(0, 0, 0, Q_ONE, 1 << 16, 0, 0), 1'b0, s_zero);
        add_row(1'b0, rot_z, make_pose(QMIN, 0, 0, 0, 1, -1, 3), 1'b0, s_zero);
        add_row(1'b1, flip_x, make_pose(0, 0, 0, Q_ONE, 0, 1 << 16, 1 << 16), 1'b0, s_zero);
        // Cross products that land exactly halfway, once each way round.
        add_row(1'b1, half_step, make_pose(0, 0, 0, Q_ONE, 0, 4096, 0), 1'b0, s_zero);
        add_row(1'b0, half_step, make_pose(0, 0, 0, Q_ONE, 0, -4096, 0), 1'b0, s_zero);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].load)
            begin
                quiesce_stream();
                load_parent(directed_rows[i].parent);
            end
            send_pose(directed_rows[i].stim, directed_rows[i].typed, directed_rows[i].want);
        end

        for (int ph = 0; ph < 6; ph++)
        begin
            quiesce_stream();
            load_parent(random_pose());
            case (ph % 4)
                1:
                begin
                    send_idle_pct  = 64;
                    sink_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    sink_stall_pct = 64;
                end
                3:
                begin
                    send_idle_pct  = 30;
                    sink_stall_pct = 30;
                end
                default:
                begin
                    send_idle_pct  = 0;
                    sink_stall_pct = 0;
                end
            endcase
            if (ph == 4)
            begin
                backpressure_cycles = 300;
            end
            repeat (325) send_pose(random_pose(), 1'b0, s_zero);
        end

        quiesce_stream();
        repeat (20) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("tb_rigid_pose_compose: PASS");
        end
        else
        begin
            $display("tb_rigid_pose_compose: FAIL");
        end
        $finish;
    end

endmodule
